@@ rtl/core/lewh_pkg.sv @@
// ----------------------------------------------------------------------------
// Line editor package
// Shared sizes, key codes, result kinds, register indices, cell control types and state codes.
// ----------------------------------------------------------------------------
package lewh_pkg;

  localparam int LINE_CAP   = 64;
  localparam int HIST_DEPTH = 16;

  localparam int PW = $clog2(LINE_CAP);
  localparam int KW = $clog2(LINE_CAP + 1);
  localparam int SW = $clog2(HIST_DEPTH);
  localparam int FW = $clog2(HIST_DEPTH + 1);
  localparam int AW = $clog2(HIST_DEPTH * LINE_CAP);

  localparam logic [7:0] KEY_NEWLINE   = 8'd10;
  localparam logic [7:0] KEY_BACKSPACE = 8'd8;
  localparam logic [7:0] PRINT_LOW     = 8'd32;
  localparam logic [7:0] PRINT_HIGH    = 8'd126;
  localparam logic [7:0] SPACE_CHAR    = 8'd32;

  localparam logic [1:0] KIND_REDRAW     = 2'd0;
  localparam logic [1:0] KIND_REDRAW_NIL = 2'd1;
  localparam logic [1:0] KIND_CMD        = 2'd2;
  localparam logic [1:0] KIND_CMD_NIL    = 2'd3;

  localparam logic [1:0] REG_LEFT  = 2'd0;
  localparam logic [1:0] REG_RIGHT = 2'd1;
  localparam logic [1:0] REG_UP    = 2'd2;
  localparam logic [1:0] REG_DOWN  = 2'd3;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_SET,
    CELL_FROM_PREV,
    CELL_FROM_NEXT
  } cell_op_e;

  typedef struct packed {
    cell_op_e   op;
    logic [7:0] key;
  } cell_ctrl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_TRIM,
    ST_EMIT
  } state_e;

endpackage

@@ rtl/core/lewh_cell.sv @@
// ----------------------------------------------------------------------------
// Line cell
// One character of the edit line; loads a key or a neighbour's character.
// ----------------------------------------------------------------------------
module lewh_cell (
  input  logic                clk_i,
  input  lewh_pkg::cell_ctrl_t ctrl_i,
  input  logic [7:0]          prev_i,
  input  logic [7:0]          next_i,
  output logic [7:0]          data_o
);

  logic [7:0] data_q, data_d;

  always_comb begin
    case (ctrl_i.op)
      lewh_pkg::CELL_SET:       data_d = ctrl_i.key;
      lewh_pkg::CELL_FROM_PREV: data_d = prev_i;
      lewh_pkg::CELL_FROM_NEXT: data_d = next_i;
      default:                  data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

@@ rtl/core/line_editor_with_history.sv @@
// ----------------------------------------------------------------------------
// Line editor with history
// Edit line held in a row of character cells, history ring in a memory.
// ----------------------------------------------------------------------------
// One key per transfer. Cursor moves, insert and delete are applied first, then
// the line is rotated once round the cell row while each character is
// emitted from the head cell. History recall first streams the entry from
// the history memory into the row; Enter scans the row once for leading
// spaces, then rotates again while emitting the command and writing it to the
// history memory. Output stalls hold the rotation. A new key is taken only
// when the previous one is fully handled.
module line_editor_with_history (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] key_code
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [7:0] char_out, [13:8] position,
                                 // [19:14] cursor_at, [25:20] length_now
  output logic [1:0]  m_tuser,   // [1:0] kind
  output logic        m_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int CAP = lewh_pkg::LINE_CAP;
  localparam int HD  = lewh_pkg::HIST_DEPTH;
  localparam int PW  = lewh_pkg::PW;
  localparam int KW  = lewh_pkg::KW;
  localparam int SW  = lewh_pkg::SW;
  localparam int FW  = lewh_pkg::FW;
  localparam int AW  = lewh_pkg::AW;

  logic [7:0] code_left_q, code_right_q, code_up_q, code_down_q;

  lewh_pkg::state_e state_q, state_d;
  logic [PW-1:0] len_q, len_d, cur_q, cur_d, lead_q, lead_d;
  logic [KW-1:0] k_q, k_d;
  logic          cmd_q, cmd_d, scan_q, scan_d;
  logic [SW-1:0] wslot_q, wslot_d, lslot_q, lslot_d;
  logic [FW-1:0] filled_q, filled_d, recall_q, recall_d;

  logic [PW-1:0] hist_len [HD];
  logic [7:0]    hist_mem [HD*CAP];
  logic [7:0]    rd_data_q;
  logic [AW-1:0] rd_addr, wr_addr;
  logic          wr_en;

  logic          out_valid_q, out_valid_d, out_last_q, out_last_d;
  logic [1:0]    out_kind_q, out_kind_d;
  logic [7:0]    out_char_q, out_char_d;
  logic [PW-1:0] out_pos_q, out_pos_d, out_cur_q, out_cur_d, out_len_q, out_len_d;

  logic [7:0]    cell_q [CAP];
  logic [7:0]    tail_next;
  logic          accept, out_free, rotate, do_ins, do_del, load_shift;
  logic [7:0]    key;
  logic          is_left, is_right, is_up, is_down, is_nl, is_bs, is_pr;
  logic [FW-1:0] rec_up, rec_dn, rec_new;
  logic [SW:0]   slot_sum;
  logic [SW-1:0] slot_new;
  logic [PW-1:0] cmd_n, len_e;
  logic          k_in_run;

  // ---------------------------------------------------------------- config
  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_left_q  <= 8'd128;
      code_right_q <= 8'd129;
      code_up_q    <= 8'd130;
      code_down_q  <= 8'd131;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[3:2])
        lewh_pkg::REG_LEFT:  code_left_q  <= pwdata[7:0];
        lewh_pkg::REG_RIGHT: code_right_q <= pwdata[7:0];
        lewh_pkg::REG_UP:    code_up_q    <= pwdata[7:0];
        lewh_pkg::REG_DOWN:  code_down_q  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      lewh_pkg::REG_LEFT:  prdata = {24'd0, code_left_q};
      lewh_pkg::REG_RIGHT: prdata = {24'd0, code_right_q};
      lewh_pkg::REG_UP:    prdata = {24'd0, code_up_q};
      lewh_pkg::REG_DOWN:  prdata = {24'd0, code_down_q};
      default:             prdata = 32'd0;
    endcase
  end

  // ---------------------------------------------------------------- decode
  assign key      = s_tdata;
  assign accept   = s_tvalid && s_tready;
  assign out_free = !out_valid_q || m_tready;

  assign is_left  = key == code_left_q;
  assign is_right = !is_left && key == code_right_q;
  assign is_up    = !is_left && !is_right && key == code_up_q;
  assign is_down  = !is_left && !is_right && !is_up && key == code_down_q;
  assign is_nl    = !is_left && !is_right && !is_up && !is_down &&
                    key == lewh_pkg::KEY_NEWLINE;
  assign is_bs    = !is_left && !is_right && !is_up && !is_down && !is_nl &&
                    key == lewh_pkg::KEY_BACKSPACE;
  assign is_pr    = !is_left && !is_right && !is_up && !is_down && !is_nl && !is_bs &&
                    key >= lewh_pkg::PRINT_LOW && key <= lewh_pkg::PRINT_HIGH;

  assign do_ins = accept && is_pr && (len_q < PW'(CAP - 1));
  assign do_del = accept && is_bs && (cur_q != '0);

  assign rec_up   = recall_q + FW'(1);
  assign rec_dn   = recall_q - FW'(1);
  assign rec_new  = is_up ? rec_up : rec_dn;
  assign slot_sum = {1'b0, wslot_q} + (SW+1)'(HD) - (SW+1)'(rec_new);
  assign slot_new = (slot_sum >= (SW+1)'(HD)) ? SW'(slot_sum - (SW+1)'(HD))
                                               : SW'(slot_sum);

  assign cmd_n    = len_q - lead_q;
  assign len_e    = cmd_q ? cmd_n : len_q;
  assign k_in_run = cmd_q ? (k_q >= KW'(lead_q) && k_q < KW'(len_q))
                          : (k_q < KW'(len_q));

  // ---------------------------------------------------------------- cells
  assign rotate     = (state_q == lewh_pkg::ST_TRIM) ||
                      (state_q == lewh_pkg::ST_EMIT && out_free && len_e != '0);
  assign load_shift = (state_q == lewh_pkg::ST_LOAD) && (k_q != '0);
  assign tail_next  = load_shift ? rd_data_q : cell_q[0];

  for (genvar i = 0; i < CAP; i++) begin : g_cell
    lewh_pkg::cell_ctrl_t ctrl;
    logic [7:0] prev_c, next_c;

    always_comb begin
      ctrl.key = key;
      ctrl.op  = lewh_pkg::CELL_HOLD;
      if (do_ins) begin
        if (PW'(i) == cur_q)     ctrl.op = lewh_pkg::CELL_SET;
        else if (PW'(i) > cur_q) ctrl.op = lewh_pkg::CELL_FROM_PREV;
      end else if (do_del) begin
        if (PW'(i) >= cur_q - PW'(1)) ctrl.op = lewh_pkg::CELL_FROM_NEXT;
      end else if (rotate || load_shift) begin
        ctrl.op = lewh_pkg::CELL_FROM_NEXT;
      end
    end

    if (i == 0) begin : g_head
      assign prev_c = key;
    end else begin : g_body
      assign prev_c = cell_q[i-1];
    end
    if (i == CAP - 1) begin : g_tail
      assign next_c = tail_next;
    end else begin : g_mid
      assign next_c = cell_q[i+1];
    end

    lewh_cell u_cell (
      .clk_i  (clk_i),
      .ctrl_i (ctrl),
      .prev_i (prev_c),
      .next_i (next_c),
      .data_o (cell_q[i])
    );
  end

  // ---------------------------------------------------------------- memory
  assign rd_addr = AW'(lslot_q) * AW'(CAP) + AW'(k_q[PW-1:0]);
  assign wr_addr = AW'(wslot_q) * AW'(CAP) + AW'(PW'(k_q[PW-1:0] - lead_q));
  assign wr_en   = state_q == lewh_pkg::ST_EMIT && cmd_q && out_free &&
                   cmd_n != '0 && k_in_run;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      hist_mem[wr_addr] <= cell_q[0];
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_q <= hist_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (state_q == lewh_pkg::ST_EMIT && cmd_q && out_free && cmd_n != '0 &&
        k_q == KW'(CAP - 1)) begin
      hist_len[wslot_q] <= cmd_n;
    end
  end

  // ---------------------------------------------------------------- control
  always_comb begin
    state_d     = state_q;
    len_d       = len_q;
    cur_d       = cur_q;
    lead_d      = lead_q;
    k_d         = k_q;
    cmd_d       = cmd_q;
    scan_d      = scan_q;
    wslot_d     = wslot_q;
    lslot_d     = lslot_q;
    filled_d    = filled_q;
    recall_d    = recall_q;
    out_valid_d = out_valid_q && !m_tready;
    out_kind_d  = out_kind_q;
    out_char_d  = out_char_q;
    out_pos_d   = out_pos_q;
    out_cur_d   = out_cur_q;
    out_len_d   = out_len_q;
    out_last_d  = out_last_q;

    case (state_q)
      lewh_pkg::ST_IDLE: begin
        k_d = '0;
        if (accept) begin
          cmd_d = 1'b0;
          if (is_left) begin
            if (cur_q != '0) begin
              cur_d   = cur_q - PW'(1);
              state_d = lewh_pkg::ST_EMIT;
            end
          end else if (is_right) begin
            if (cur_q < len_q) begin
              cur_d   = cur_q + PW'(1);
              state_d = lewh_pkg::ST_EMIT;
            end
          end else if (is_up) begin
            if (recall_q < filled_q) begin
              recall_d = rec_up;
              lslot_d  = slot_new;
              len_d    = hist_len[slot_new];
              cur_d    = hist_len[slot_new];
              state_d  = lewh_pkg::ST_LOAD;
            end
          end else if (is_down) begin
            if (recall_q != '0) begin
              recall_d = rec_dn;
              if (rec_dn == '0) begin
                len_d   = '0;
                cur_d   = '0;
                state_d = lewh_pkg::ST_EMIT;
              end else begin
                lslot_d = slot_new;
                len_d   = hist_len[slot_new];
                cur_d   = hist_len[slot_new];
                state_d = lewh_pkg::ST_LOAD;
              end
            end
          end else if (is_nl) begin
            cmd_d   = 1'b1;
            lead_d  = '0;
            scan_d  = 1'b1;
            state_d = lewh_pkg::ST_TRIM;
          end else if (is_bs) begin
            if (do_del) begin
              len_d   = len_q - PW'(1);
              cur_d   = cur_q - PW'(1);
              state_d = lewh_pkg::ST_EMIT;
            end
          end else if (do_ins) begin
            len_d   = len_q + PW'(1);
            cur_d   = cur_q + PW'(1);
            state_d = lewh_pkg::ST_EMIT;
          end
        end
      end

      lewh_pkg::ST_LOAD: begin
        k_d = k_q + KW'(1);
        if (k_q == KW'(CAP)) begin
          k_d     = '0;
          state_d = lewh_pkg::ST_EMIT;
        end
      end

      lewh_pkg::ST_TRIM: begin
        if (scan_q && k_q < KW'(len_q) && cell_q[0] == lewh_pkg::SPACE_CHAR) begin
          lead_d = lead_q + PW'(1);
        end else begin
          scan_d = 1'b0;
        end
        k_d = k_q + KW'(1);
        if (k_q == KW'(CAP - 1)) begin
          k_d     = '0;
          state_d = lewh_pkg::ST_EMIT;
        end
      end

      lewh_pkg::ST_EMIT: begin
        if (out_free) begin
          if (len_e == '0) begin
            out_valid_d = 1'b1;
            out_kind_d  = cmd_q ? lewh_pkg::KIND_CMD_NIL : lewh_pkg::KIND_REDRAW_NIL;
            out_char_d  = '0;
            out_pos_d   = '0;
            out_cur_d   = cmd_q ? '0 : cur_q;
            out_len_d   = '0;
            out_last_d  = 1'b1;
            if (cmd_q) begin
              len_d = '0;
              cur_d = '0;
            end
            state_d = lewh_pkg::ST_IDLE;
          end else begin
            if (k_in_run) begin
              out_valid_d = 1'b1;
              out_kind_d  = cmd_q ? lewh_pkg::KIND_CMD : lewh_pkg::KIND_REDRAW;
              out_char_d  = cell_q[0];
              out_pos_d   = k_q[PW-1:0] - (cmd_q ? lead_q : PW'(0));
              out_cur_d   = cmd_q ? '0 : cur_q;
              out_len_d   = len_e;
              out_last_d  = k_q == KW'(len_q) - KW'(1);
            end
            k_d = k_q + KW'(1);
            if (k_q == KW'(CAP - 1)) begin
              k_d = '0;
              if (cmd_q) begin
                wslot_d  = (wslot_q == SW'(HD - 1)) ? '0 : wslot_q + SW'(1);
                filled_d = (filled_q == FW'(HD)) ? filled_q : filled_q + FW'(1);
                recall_d = '0;
                len_d    = '0;
                cur_d    = '0;
              end
              state_d = lewh_pkg::ST_IDLE;
            end
          end
        end
      end

      default: state_d = lewh_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready = state_q == lewh_pkg::ST_IDLE;
    m_tvalid = out_valid_q;
    m_tuser  = out_kind_q;
    m_tlast  = out_last_q;
    m_tdata  = {6'd0, out_len_q, out_cur_q, out_pos_q, out_char_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lewh_pkg::ST_IDLE;
      len_q       <= '0;
      cur_q       <= '0;
      lead_q      <= '0;
      k_q         <= '0;
      cmd_q       <= 1'b0;
      scan_q      <= 1'b0;
      wslot_q     <= '0;
      lslot_q     <= '0;
      filled_q    <= '0;
      recall_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      cur_q       <= cur_d;
      lead_q      <= lead_d;
      k_q         <= k_d;
      cmd_q       <= cmd_d;
      scan_q      <= scan_d;
      wslot_q     <= wslot_d;
      lslot_q     <= lslot_d;
      filled_q    <= filled_d;
      recall_q    <= recall_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_kind_q <= out_kind_d;
    out_char_q <= out_char_d;
    out_pos_q  <= out_pos_d;
    out_cur_q  <= out_cur_d;
    out_len_q  <= out_len_d;
    out_last_q <= out_last_d;
  end

endmodule

@@ tb/lewh_checker.sv @@
// ----------------------------------------------------------------------------
// Line editor checker
// Watches the key, result and register ports, keeps its own copy of the edit
// line, cursor and history ring, predicts every result run and compares each
// result transfer field by field with the oldest predicted one.
// ----------------------------------------------------------------------------
module lewh_checker
  import lewh_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [31:0] m_tdata,
  input  logic [1:0]  m_tuser,
  input  logic        m_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] ch;
    logic [5:0] pos;
    logic [5:0] cur;
    logic [5:0] len;
    logic       last;
  } edit_result_t;

  edit_result_t result_q[$];

  logic [7:0] key_left, key_right, key_up, key_down;
  logic [7:0] line_buf [LINE_CAP];
  logic [7:0] hist_buf [HIST_DEPTH][LINE_CAP];
  logic [5:0] hist_len [HIST_DEPTH];
  int         edit_len, edit_cur, wr_slot, hist_count, recall_depth;

  assign pending = result_q.size();

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    fail_count++;
  endtask

  task automatic push_result(input logic [1:0] kind, input logic [7:0] ch,
                             input int pos, input int cur, input int len,
                             input logic last);
    edit_result_t r;
    r.kind = kind;
    r.ch   = ch;
    r.pos  = pos[5:0];
    r.cur  = cur[5:0];
    r.len  = len[5:0];
    r.last = last;
    result_q.push_back(r);
  endtask

  task automatic push_redraw();
    if (edit_len == 0) begin
      push_result(KIND_REDRAW_NIL, 8'd0, 0, edit_cur, 0, 1'b1);
    end else begin
      for (int i = 0; i < edit_len; i++)
        push_result(KIND_REDRAW, line_buf[i], i, edit_cur, edit_len, i == edit_len - 1);
    end
  endtask

  task automatic recall_entry();
    int slot;
    int n;
    slot = (wr_slot + HIST_DEPTH - recall_depth) % HIST_DEPTH;
    n = hist_len[slot];
    if (n > LINE_CAP - 1) n = LINE_CAP - 1;
    for (int i = 0; i < n; i++) line_buf[i] = hist_buf[slot][i];
    edit_len = n;
    edit_cur = n;
  endtask

  task automatic predict_key(input logic [7:0] k);
    int lead;
    int n;
    if (k == key_left) begin
      if (edit_cur == 0) return;
      edit_cur--;
      push_redraw();
    end else if (k == key_right) begin
      if (edit_cur >= edit_len) return;
      edit_cur++;
      push_redraw();
    end else if (k == key_up) begin
      if (recall_depth >= hist_count) return;
      recall_depth++;
      recall_entry();
      push_redraw();
    end else if (k == key_down) begin
      if (recall_depth == 0) return;
      recall_depth--;
      if (recall_depth == 0) begin
        edit_len = 0;
        edit_cur = 0;
      end else begin
        recall_entry();
      end
      push_redraw();
    end else if (k == KEY_NEWLINE) begin
      lead = 0;
      while (lead < edit_len && line_buf[lead] == SPACE_CHAR) lead++;
      n = edit_len - lead;
      if (n == 0) begin
        push_result(KIND_CMD_NIL, 8'd0, 0, 0, 0, 1'b1);
      end else begin
        for (int i = 0; i < n; i++) begin
          hist_buf[wr_slot][i] = line_buf[lead + i];
          push_result(KIND_CMD, line_buf[lead + i], i, 0, n, i == n - 1);
        end
        hist_len[wr_slot] = n[5:0];
        wr_slot = (wr_slot + 1) % HIST_DEPTH;
        if (hist_count < HIST_DEPTH) hist_count++;
        recall_depth = 0;
      end
      edit_len = 0;
      edit_cur = 0;
    end else if (k == KEY_BACKSPACE) begin
      if (edit_cur == 0) return;
      for (int i = edit_cur; i < edit_len; i++) line_buf[i - 1] = line_buf[i];
      edit_len--;
      edit_cur--;
      push_redraw();
    end else if (k >= PRINT_LOW && k <= PRINT_HIGH) begin
      if (edit_len >= LINE_CAP - 1) return;
      for (int i = edit_len; i > edit_cur; i--) line_buf[i] = line_buf[i - 1];
      line_buf[edit_cur] = k;
      edit_len++;
      edit_cur++;
      push_redraw();
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    edit_result_t got, want;
    if (!rst_ni) begin
      key_left     <= 8'd128;
      key_right    <= 8'd129;
      key_up       <= 8'd130;
      key_down     <= 8'd131;
      edit_len     = 0;
      edit_cur     = 0;
      wr_slot      = 0;
      hist_count   = 0;
      recall_depth = 0;
      fail_count   = 0;
      result_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_LEFT:  key_left  <= pwdata[7:0];
          REG_RIGHT: key_right <= pwdata[7:0];
          REG_UP:    key_up    <= pwdata[7:0];
          REG_DOWN:  key_down  <= pwdata[7:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) predict_key(s_tdata);
      if (m_tvalid && m_tready) begin
        got.kind = m_tuser;
        got.ch   = m_tdata[7:0];
        got.pos  = m_tdata[13:8];
        got.cur  = m_tdata[19:14];
        got.len  = m_tdata[25:20];
        got.last = m_tlast;
        if (result_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result kind=%0d char=%0d pos=%0d",
                                    got.kind, got.ch, got.pos));
        end else begin
          want = result_q.pop_front();
          if (got.kind !== want.kind || got.ch !== want.ch || got.pos !== want.pos ||
              got.cur !== want.cur || got.len !== want.len || got.last !== want.last)
            report_mismatch($sformatf(
              "kind %0d/%0d char %0d/%0d pos %0d/%0d cur %0d/%0d len %0d/%0d last %0d/%0d",
              got.kind, want.kind, got.ch, want.ch, got.pos, want.pos,
              got.cur, want.cur, got.len, want.len, got.last, want.last));
        end
      end
    end
  end

endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// Line editor testbench
// Drives key transfers in bursts and register writes between phases, stalls
// the result channel, and takes the verdict from the checker.
// ----------------------------------------------------------------------------
module tb_top;
  import lewh_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'd0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = 4'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;
  int          fail_count;
  int          pending;
  int          cycles = 0;
  int          burst_left = 0;
  int          rx_mode = 0;
  int          rx_left = 0;
  logic [7:0]  cur_codes [4];

  always #4 clk_i = ~clk_i;

  line_editor_with_history u_dut (
    .clk_i, .rst_ni, .s_tvalid, .s_tready, .s_tdata, .m_tvalid, .m_tready,
    .m_tdata, .m_tuser, .m_tlast, .psel, .penable, .pwrite, .paddr, .pwdata,
    .prdata, .pready
  );

  lewh_checker u_checker (
    .clk_i, .rst_ni, .s_tvalid, .s_tready, .s_tdata, .m_tvalid, .m_tready,
    .m_tdata, .m_tuser, .m_tlast, .psel, .penable, .pwrite, .paddr, .pwdata,
    .pready, .fail_count, .pending
  );

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 2);
      rx_left = $urandom_range(20, 200);
    end else begin
      rx_left--;
    end
    case (rx_mode)
      0:       m_tready <= 1'b1;
      1:       m_tready <= 1'($urandom_range(0, 1));
      default: m_tready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  task automatic write_code(input logic [1:0] idx, input logic [7:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {24'($urandom_range(0, 16777215)), val};
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cur_codes[idx] = val;
  endtask

  task automatic set_codes(input logic [7:0] l, input logic [7:0] r,
                           input logic [7:0] u, input logic [7:0] d);
    write_code(REG_LEFT, l);
    write_code(REG_RIGHT, r);
    write_code(REG_UP, u);
    write_code(REG_DOWN, d);
  endtask

  task automatic send_key(input logic [7:0] k);
    s_tvalid <= 1'b1;
    s_tdata  <= k;
    do @(posedge clk_i); while (!s_tready);
    @(negedge clk_i);
    if (burst_left == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(0, 30)) @(negedge clk_i);
      burst_left = $urandom_range(0, 12);
    end else begin
      burst_left--;
    end
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (300) @(negedge clk_i);
  endtask

  function automatic logic [7:0] pick_key();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 55) return 8'($urandom_range(PRINT_LOW, PRINT_HIGH));
    if (sel < 80) return cur_codes[$urandom_range(0, 3)];
    if (sel < 88) return KEY_NEWLINE;
    if (sel < 95) return KEY_BACKSPACE;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic random_phase(input int n_keys, input logic fill);
    for (int i = 0; i < n_keys; i++) begin
      if (fill && i == n_keys / 2) begin
        repeat (66) send_key(8'($urandom_range(PRINT_LOW, PRINT_HIGH)));
      end
      send_key(pick_key());
    end
  endtask

  initial begin
    logic [7:0] opening [25];
    cur_codes = '{8'd128, 8'd129, 8'd130, 8'd131};
    opening = '{KEY_BACKSPACE, 8'd128, 8'd129, 8'd130, 8'd131, KEY_NEWLINE,
                SPACE_CHAR, SPACE_CHAR, KEY_NEWLINE, SPACE_CHAR, 8'd97, PRINT_HIGH,
                8'd128, KEY_BACKSPACE, 8'd129, 8'd129, KEY_NEWLINE, 8'd130,
                8'd130, 8'd131, 8'd0, 8'd255, 8'd127, 8'd33, KEY_NEWLINE};
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (2) @(negedge clk_i);
    foreach (opening[i]) send_key(opening[i]);
    random_phase(60, 1'b1);
    drain();
    set_codes(8'd8, 8'd255, 8'd10, 8'd32);
    random_phase(60, 1'b0);
    drain();
    set_codes(8'd0, 8'($urandom_range(132, 254)), 8'($urandom_range(132, 254)),
              8'($urandom_range(132, 254)));
    random_phase(60, 1'b0);
    drain();
    set_codes(8'd200, 8'd201, 8'd202, 8'd203);
    random_phase(60, 1'b0);
    s_tvalid <= 1'b0;
    drain();
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ line_editor_with_history.f @@
rtl/core/lewh_pkg.sv
rtl/core/lewh_cell.sv
rtl/core/line_editor_with_history.sv
tb/lewh_checker.sv
tb/tb_top.sv
